>>> design/yfc_pkg.sv
// ----------------------------------------------------------------------------
// yfc_pkg: shared types, constants and helpers of the YUV frame crossfade
// Holds the coefficient table in units of 1e-5, the stage enable bundle
// handed to the color converter, and the 0..255 saturation of the output stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package yfc_pkg;

  // Default fractional bits of the fixed-point coefficients
  localparam int unsigned DefCoefFracBits = 16;

  // Width of a signed channel sum before saturation
  localparam int unsigned SumW = 13;

  // YUV to RGB coefficient magnitudes, units of 1e-5
  localparam longint KRv = 140200;
  localparam longint KGu = 34413;
  localparam longint KGv = 71414;
  localparam longint KBu = 177200;

  // RGB to YUV coefficient magnitudes, units of 1e-5
  localparam longint KYr = 29900;
  localparam longint KYg = 58700;
  localparam longint KYb = 11400;
  localparam longint KUr = 16870;
  localparam longint KUg = 33130;
  localparam longint KUb = 50000;
  localparam longint KVr = 50000;
  localparam longint KVg = 41870;
  localparam longint KVb = 8130;

  // Rounding offset and scale for the coefficient table
  localparam longint KHalf  = 50000;
  localparam longint KScale = 100000;

  // Chroma offset
  localparam logic [7:0] ChromaOfs = 8'd128;

  // Load enables of the two register stages inside the color converter
  typedef struct packed {
    logic s0;
    logic s1;
  } yfc_rgb_en_t;

  // Clamp a signed channel sum to 0..255
  function automatic logic [7:0] sat8(input logic signed [SumW-1:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > SumW'(255)) begin
      r = 8'hFF;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

>>> design/yfc_intf.sv
// ----------------------------------------------------------------------------
// yfc_intf: stream channels of the YUV frame crossfade
// Pixel pair input, mixed pixel output and the blend weight write channel,
// each a valid/ready channel with source and sink modports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface yfc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_first;
  logic [7:0] cb_first;
  logic [7:0] cr_first;
  logic [7:0] luma_second;
  logic [7:0] cb_second;
  logic [7:0] cr_second;

  modport source (
    output valid, luma_first, cb_first, cr_first, luma_second, cb_second, cr_second,
    input  ready
  );
  modport sink (
    input  valid, luma_first, cb_first, cr_first, luma_second, cb_second, cr_second,
    output ready
  );
endinterface

interface yfc_mix_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_mixed;
  logic [7:0] cb_mixed;
  logic [7:0] cr_mixed;

  modport source (
    output valid, luma_mixed, cb_mixed, cr_mixed,
    input  ready
  );
  modport sink (
    input  valid, luma_mixed, cb_mixed, cr_mixed,
    output ready
  );
endinterface

interface yfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] blend_weight;

  modport source (
    output valid, blend_weight,
    input  ready
  );
  modport sink (
    input  valid, blend_weight,
    output ready
  );
endinterface

>>> design/yfc_to_rgb.sv
// ----------------------------------------------------------------------------
// yfc_to_rgb: two-stage full-range YUV to RGB converter
// Stage 0 registers the four coefficient products, stage 1 truncates them
// toward zero, adds luma and saturates each channel to 0..255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yfc_to_rgb import yfc_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = DefCoefFracBits
) (
  input  logic        clk_i,
  input  yfc_rgb_en_t en_i,
  input  logic [7:0]  luma_i,
  input  logic [7:0]  cb_i,
  input  logic [7:0]  cr_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o
);

  // Coefficient magnitude, signed product and truncated term widths
  localparam int unsigned CW = COEF_FRAC_BITS + 1;
  localparam int unsigned PW = CW + 10;
  localparam int unsigned TW = PW - COEF_FRAC_BITS;

  localparam logic [CW-1:0] QRv = CW'(((KRv << COEF_FRAC_BITS) + KHalf) / KScale);
  localparam logic [CW-1:0] QGu = CW'(((KGu << COEF_FRAC_BITS) + KHalf) / KScale);
  localparam logic [CW-1:0] QGv = CW'(((KGv << COEF_FRAC_BITS) + KHalf) / KScale);
  localparam logic [CW-1:0] QBu = CW'(((KBu << COEF_FRAC_BITS) + KHalf) / KScale);

  localparam logic signed [PW-1:0] RndBias = PW'((longint'(1) << COEF_FRAC_BITS) - 1);

  // Divide by 2^COEF_FRAC_BITS, truncating toward zero
  function automatic logic signed [TW-1:0] trunc_div(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + (p[PW-1] ? RndBias : '0);
    return s[PW-1:COEF_FRAC_BITS];
  endfunction

  logic signed [8:0]    du;
  logic signed [8:0]    dv;
  logic [7:0]           luma_q;
  logic signed [PW-1:0] prv_q, prv_d;
  logic signed [PW-1:0] pgu_q, pgu_d;
  logic signed [PW-1:0] pgv_q, pgv_d;
  logic signed [PW-1:0] pbu_q, pbu_d;

  logic signed [SumW-1:0] sum_r;
  logic signed [SumW-1:0] sum_g;
  logic signed [SumW-1:0] sum_b;
  logic [7:0]             red_q, red_d;
  logic [7:0]             green_q, green_d;
  logic [7:0]             blue_q, blue_d;

  // Remove chroma offset and form the products
  always_comb begin
    du    = signed'({1'b0, cb_i}) - signed'({1'b0, ChromaOfs});
    dv    = signed'({1'b0, cr_i}) - signed'({1'b0, ChromaOfs});
    prv_d = PW'(signed'({1'b0, QRv})) * PW'(dv);
    pgu_d = PW'(signed'({1'b0, QGu})) * PW'(du);
    pgv_d = PW'(signed'({1'b0, QGv})) * PW'(dv);
    pbu_d = PW'(signed'({1'b0, QBu})) * PW'(du);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s0) begin
      luma_q <= luma_i;
      prv_q  <= prv_d;
      pgu_q  <= pgu_d;
      pgv_q  <= pgv_d;
      pbu_q  <= pbu_d;
    end
  end

  // Truncate, add luma and saturate
  always_comb begin
    sum_r   = signed'(SumW'(luma_q)) + SumW'(trunc_div(prv_q));
    sum_g   = signed'(SumW'(luma_q)) - SumW'(trunc_div(pgu_q)) - SumW'(trunc_div(pgv_q));
    sum_b   = signed'(SumW'(luma_q)) + SumW'(trunc_div(pbu_q));
    red_d   = sat8(sum_r);
    green_d = sat8(sum_g);
    blue_d  = sat8(sum_b);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

>>> design/yuv_frame_crossfade_core.sv
// ----------------------------------------------------------------------------
// yuv_frame_crossfade_core: crossfade of two co-sited full-range YUV pixels
// Throughput: one pixel pair per cycle; an output stall holds each occupied
// stage whose successor cannot load, while empty stages still fill.
// Six stages: products, RGB, blend products, blend sum, YUV products, YUV.
// Reset clears all stage valid bits and sets the blend weight to 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yuv_frame_crossfade_core import yfc_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = DefCoefFracBits
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  yfc_cfg_if.sink   cfg_i,
  yfc_pix_if.sink   pix_i,
  yfc_mix_if.source mix_o
);

  localparam int unsigned NStages = 6;
  localparam int unsigned CW      = COEF_FRAC_BITS + 1;
  localparam int unsigned UW      = CW + 8;

  localparam logic [CW-1:0] QYr = CW'(((KYr << COEF_FRAC_BITS) + KHalf) / KScale);
  localparam logic [CW-1:0] QYg = CW'(((KYg << COEF_FRAC_BITS) + KHalf) / KScale);
  localparam logic [CW-1:0] QYb = CW'(((KYb << COEF_FRAC_BITS) + KHalf) / KScale);
  localparam logic [CW-1:0] QUr = CW'(((KUr << COEF_FRAC_BITS) + KHalf) / KScale);
  localparam logic [CW-1:0] QUg = CW'(((KUg << COEF_FRAC_BITS) + KHalf) / KScale);
  localparam logic [CW-1:0] QUb = CW'(((KUb << COEF_FRAC_BITS) + KHalf) / KScale);
  localparam logic [CW-1:0] QVr = CW'(((KVr << COEF_FRAC_BITS) + KHalf) / KScale);
  localparam logic [CW-1:0] QVg = CW'(((KVg << COEF_FRAC_BITS) + KHalf) / KScale);
  localparam logic [CW-1:0] QVb = CW'(((KVb << COEF_FRAC_BITS) + KHalf) / KScale);

  // --------------------------------------------------------------------------
  // Blend weight register
  // --------------------------------------------------------------------------
  logic [7:0] weight_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= 8'hFF;
    end else if (cfg_i.valid) begin
      weight_q <= cfg_i.blend_weight;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when empty or when its successor loads
  // --------------------------------------------------------------------------
  logic [NStages-1:0] vld_q, vld_d;
  logic [NStages:0]   en;
  yfc_rgb_en_t        rgb_en;

  always_comb begin
    en[NStages] = mix_o.ready;
    for (int k = NStages - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? pix_i.valid : vld_q[0];
    for (int k = 1; k < NStages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign pix_i.ready = en[0];
  assign mix_o.valid = vld_q[NStages-1];
  assign rgb_en.s0   = en[0];
  assign rgb_en.s1   = en[1];

  // --------------------------------------------------------------------------
  // Stages 0 and 1: convert both pixels to RGB
  // --------------------------------------------------------------------------
  logic [7:0] ra, ga, ba;
  logic [7:0] rb, gb, bb;

  yfc_to_rgb #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_rgb_first (
    .clk_i  (clk_i),
    .en_i   (rgb_en),
    .luma_i (pix_i.luma_first),
    .cb_i   (pix_i.cb_first),
    .cr_i   (pix_i.cr_first),
    .red_o  (ra),
    .green_o(ga),
    .blue_o (ba)
  );

  yfc_to_rgb #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_rgb_second (
    .clk_i  (clk_i),
    .en_i   (rgb_en),
    .luma_i (pix_i.luma_second),
    .cb_i   (pix_i.cb_second),
    .cr_i   (pix_i.cr_second),
    .red_o  (rb),
    .green_o(gb),
    .blue_o (bb)
  );

  // --------------------------------------------------------------------------
  // Stage 2: weight both channels
  // --------------------------------------------------------------------------
  logic [8:0]  weight_c;
  logic [15:0] wa_r_q, wa_g_q, wa_b_q;
  logic [16:0] wb_r_q, wb_g_q, wb_b_q;

  assign weight_c = 9'd256 - {1'b0, weight_q};

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      wa_r_q <= 16'(ra) * 16'(weight_q);
      wa_g_q <= 16'(ga) * 16'(weight_q);
      wa_b_q <= 16'(ba) * 16'(weight_q);
      wb_r_q <= 17'(rb) * 17'(weight_c);
      wb_g_q <= 17'(gb) * 17'(weight_c);
      wb_b_q <= 17'(bb) * 17'(weight_c);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: add and drop the eight weight bits
  // --------------------------------------------------------------------------
  logic [16:0] mix_r, mix_g, mix_b;
  logic [7:0]  m_r_q, m_g_q, m_b_q;

  always_comb begin
    mix_r = 17'(wa_r_q) + wb_r_q;
    mix_g = 17'(wa_g_q) + wb_g_q;
    mix_b = 17'(wa_b_q) + wb_b_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      m_r_q <= mix_r[15:8];
      m_g_q <= mix_g[15:8];
      m_b_q <= mix_b[15:8];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: RGB to YUV products
  // --------------------------------------------------------------------------
  logic [UW-1:0] p_yr_q, p_yg_q, p_yb_q;
  logic [UW-1:0] p_ur_q, p_ug_q, p_ub_q;
  logic [UW-1:0] p_vr_q, p_vg_q, p_vb_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      p_yr_q <= UW'(m_r_q) * UW'(QYr);
      p_yg_q <= UW'(m_g_q) * UW'(QYg);
      p_yb_q <= UW'(m_b_q) * UW'(QYb);
      p_ur_q <= UW'(m_r_q) * UW'(QUr);
      p_ug_q <= UW'(m_g_q) * UW'(QUg);
      p_ub_q <= UW'(m_b_q) * UW'(QUb);
      p_vr_q <= UW'(m_r_q) * UW'(QVr);
      p_vg_q <= UW'(m_g_q) * UW'(QVg);
      p_vb_q <= UW'(m_b_q) * UW'(QVb);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: truncate, sum, add chroma offset and saturate
  // --------------------------------------------------------------------------
  logic signed [SumW-1:0] sum_y, sum_u, sum_v;
  logic [7:0]             luma_q, cb_q, cr_q;

  always_comb begin
    sum_y = SumW'(p_yr_q[UW-1:COEF_FRAC_BITS]) + SumW'(p_yg_q[UW-1:COEF_FRAC_BITS])
          + SumW'(p_yb_q[UW-1:COEF_FRAC_BITS]);
    sum_u = SumW'(ChromaOfs) + SumW'(p_ub_q[UW-1:COEF_FRAC_BITS])
          - SumW'(p_ur_q[UW-1:COEF_FRAC_BITS]) - SumW'(p_ug_q[UW-1:COEF_FRAC_BITS]);
    sum_v = SumW'(ChromaOfs) + SumW'(p_vr_q[UW-1:COEF_FRAC_BITS])
          - SumW'(p_vg_q[UW-1:COEF_FRAC_BITS]) - SumW'(p_vb_q[UW-1:COEF_FRAC_BITS]);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      luma_q <= sat8(sum_y);
      cb_q   <= sat8(sum_u);
      cr_q   <= sat8(sum_v);
    end
  end

  assign mix_o.luma_mixed = luma_q;
  assign mix_o.cb_mixed   = cb_q;
  assign mix_o.cr_mixed   = cr_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A full, stalled pipeline must refuse new input
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !mix_o.ready |-> !pix_i.ready)
    else $error("input accepted while pipeline full and stalled");

  // An input transfer lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> vld_q[0])
    else $error("accepted pixel pair lost at pipeline entry");

  // A delivered result is not repeated when nothing follows it
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_o.valid && mix_o.ready && !vld_q[NStages-2] |=> !mix_o.valid)
    else $error("result repeated after output transfer");

  // The weight changes only through a configuration transfer
  a_weight_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_i.valid && cfg_i.ready) |=> $stable(weight_q))
    else $error("blend weight changed without a write");

endmodule
